>>> rtl/core/four_digit_number_display_formatter_core_assert.svh
// Assertion macros shared by the formatter RTL.
`ifndef FOUR_DIGIT_NUMBER_DISPLAY_FORMATTER_CORE_ASSERT_SVH
`define FOUR_DIGIT_NUMBER_DISPLAY_FORMATTER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset.
`define FDND_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fdnd assertion failed");

// Expression must never be true outside reset.
`define FDND_ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("fdnd forbidden condition seen");

`else

`define FDND_ASSERT(lbl, clk, rst_n, prop)
`define FDND_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

>>> rtl/core/fdnd_pkg.sv
package fdnd_pkg;

  // Field widths
  localparam int VAL_W = 25;
  localparam int BIN_W = 24;
  localparam int DIG_N = 7;
  localparam int BCD_W = 4 * DIG_N;
  localparam int CNT_W = $clog2(BIN_W);
  localparam int CODE_N = 4;

  typedef logic [7:0] code_t;
  typedef logic [3:0] bcd_digit_t;

  // Display codes
  localparam code_t CODE_MINUS = 8'h10;
  localparam code_t CODE_POINT = 8'h20;
  localparam code_t CODE_BLANK = 8'h40;
  localparam code_t CODE_DIGIT = 8'h0f;
  localparam code_t CODE_NINE  = 8'h09;
  localparam code_t CODE_ZERO  = 8'h00;

  // Item kinds
  localparam logic KIND_NUMBER = 1'b0;
  localparam logic KIND_DIGIT  = 1'b1;

  // Saturation limits, in thousandths
  localparam logic signed [VAL_W-1:0] SAT_HIGH_MILLI = 25'sd9999000;
  localparam logic signed [VAL_W-1:0] SAT_LOW_MILLI  = -25'sd999000;
  localparam logic signed [VAL_W-1:0] LAST_RESET     = 25'sd10000000;

  // Number classes decided at accept time
  typedef enum logic [1:0] {
    CLS_NUM,
    CLS_HIGH,
    CLS_LOW,
    CLS_ZERO
  } num_class_t;

endpackage

>>> rtl/core/fdnd_if.sv
// Input word channel
interface fdnd_in_if import fdnd_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic signed [VAL_W-1:0] value_milli;
  logic [2:0]              digit_position;
  code_t                   digit_code;

  modport source (output valid, kind, value_milli, digit_position, digit_code, input ready);
  modport sink (input valid, kind, value_milli, digit_position, digit_code, output ready);
endinterface

// Result word channel
interface fdnd_out_if import fdnd_pkg::*; ();
  logic  valid;
  logic  ready;
  code_t code_first;
  code_t code_second;
  code_t code_third;
  code_t code_fourth;

  modport source (output valid, code_first, code_second, code_third, code_fourth, input ready);
  modport sink (input valid, code_first, code_second, code_third, code_fourth, output ready);
endinterface

>>> rtl/core/fdnd_bcd.sv
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
module fdnd_bcd import fdnd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [BIN_W-1:0] bin,
  output logic             done,
  output bcd_digit_t       digits [DIG_N]
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [BIN_W-1:0] bin_r;
  logic [BCD_W-1:0] bcd_r;
  logic [BCD_W-1:0] adj;
  logic [BCD_W-1:0] bcd_nxt;

  // Add 3 to every digit of 5 or more, then shift in the next bit
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end else begin
        adj[4*i +: 4] = bcd_r[4*i +: 4];
      end
    end
    bcd_nxt = {adj[BCD_W-2:0], bin_r[BIN_W-1]};
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(BIN_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      bin_r <= bin;
      bcd_r <= '0;
    end else if (busy_r) begin
      bin_r <= {bin_r[BIN_W-2:0], 1'b0};
      bcd_r <= bcd_nxt;
    end
  end

  // Most significant digit first
  always_comb begin
    for (int i = 0; i < DIG_N; i++) begin
      digits[i] = bcd_r[4*(DIG_N-1-i) +: 4];
    end
  end

  assign done = done_r;

endmodule

>>> rtl/core/four_digit_number_display_formatter_core.sv
// Four-digit display formatter. A number word (kind 0) carries a signed value
// in thousandths and is turned into four display codes (0-9, minus 0x10,
// blank 0x40, point flag 0x20), saturating at 9999 and -999 and dropping
// trailing fraction zeros; a number equal to the last number formatted gives no
// result, except the first after reset. A digit word (kind 1) overwrites one
// code when its position is 1 to 4, and always gives a result. A number is
// loaded into the bit-serial BCD converter at the accept edge (one input bit
// per cycle), then formatted into the display state; a digit word is written
// there directly. The display state moves into the output register once that
// is free. The input is ready only while idle, so no word is taken while one
// is in progress; a repeated number gives nothing and the next word can follow
// on the next cycle. The output register lets the next word be accepted while
// a result waits; a second result stalls the input until the first is taken.
`include "four_digit_number_display_formatter_core_assert.svh"

module four_digit_number_display_formatter_core import fdnd_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  fdnd_in_if.sink   in_ch,
  fdnd_out_if.source out_ch
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_DONE
  } state_t;

  state_t                  state_r;
  code_t                   codes_r     [CODE_N];
  code_t                   out_code_r  [CODE_N];
  logic                    out_valid_r;
  logic signed [VAL_W-1:0] last_r;
  logic                    first_r;
  num_class_t              cls_r;
  logic                    neg_r;

  logic                    in_fire;
  logic                    repeat_hit;
  logic                    bcd_start;
  logic                    bcd_done;
  logic [VAL_W-1:0]        abs_v;
  num_class_t              cls_in;
  bcd_digit_t              d [DIG_N];
  code_t                   fmt_c [CODE_N];
  logic                    pos_ok;
  logic [1:0]              pos_idx;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // Accept-time decode
  always_comb begin
    repeat_hit = !first_r && (in_ch.value_milli == last_r);
    if (in_ch.value_milli >= SAT_HIGH_MILLI) begin
      cls_in = CLS_HIGH;
    end else if (in_ch.value_milli <= SAT_LOW_MILLI) begin
      cls_in = CLS_LOW;
    end else if (in_ch.value_milli == '0) begin
      cls_in = CLS_ZERO;
    end else begin
      cls_in = CLS_NUM;
    end
    if (in_ch.value_milli[VAL_W-1]) begin
      abs_v = ~in_ch.value_milli + 1'b1;
    end else begin
      abs_v = in_ch.value_milli;
    end
    pos_ok  = (in_ch.digit_position >= 3'd1) && (in_ch.digit_position <= 3'd4);
    pos_idx = 2'(in_ch.digit_position - 3'd1);
  end

  assign bcd_start = in_fire && (in_ch.kind == KIND_NUMBER) && !repeat_hit;

  fdnd_bcd u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bcd_start),
    .bin    (abs_v[BIN_W-1:0]),
    .done   (bcd_done),
    .digits (d)
  );

  // Digit pick, point placement and trailing-zero removal
  always_comb begin
    logic       ip_nz;
    logic [1:0] k;
    logic [2:0] pt;
    code_t      b [CODE_N];
    code_t      c [CODE_N];

    ip_nz = (d[0] != 4'd0) || (d[1] != 4'd0) || (d[2] != 4'd0) || (d[3] != 4'd0);
    if (!ip_nz) begin
      k  = 2'd3;
      pt = 3'd1;
    end else begin
      if (d[0] != 4'd0) begin
        k = 2'd0;
      end else if (d[1] != 4'd0) begin
        k = 2'd1;
      end else if (d[2] != 4'd0) begin
        k = 2'd2;
      end else begin
        k = 2'd3;
      end
      pt = 3'd4 - {1'b0, k};
    end

    for (int j = 0; j < CODE_N; j++) begin
      case (k)
        2'd0:    b[j] = {4'd0, d[j]};
        2'd1:    b[j] = {4'd0, d[j+1]};
        2'd2:    b[j] = {4'd0, d[j+2]};
        default: b[j] = {4'd0, d[j+3]};
      endcase
    end

    case (cls_r)
      CLS_HIGH: begin
        c[0] = CODE_NINE; c[1] = CODE_NINE; c[2] = CODE_NINE; c[3] = CODE_NINE;
      end
      CLS_LOW: begin
        c[0] = CODE_MINUS; c[1] = CODE_NINE; c[2] = CODE_NINE; c[3] = CODE_NINE;
      end
      CLS_ZERO: begin
        c[0] = CODE_BLANK; c[1] = CODE_BLANK; c[2] = CODE_BLANK; c[3] = CODE_ZERO;
      end
      default: begin
        if (neg_r) begin
          c[0] = CODE_MINUS; c[1] = b[0]; c[2] = b[1]; c[3] = b[2];
          if (pt == 3'd2) begin
            c[2] = c[2] | CODE_POINT;
          end else if (pt == 3'd1) begin
            c[1] = c[1] | CODE_POINT;
          end
        end else begin
          c[0] = b[0]; c[1] = b[1]; c[2] = b[2]; c[3] = b[3];
          if (pt == 3'd3) begin
            c[2] = c[2] | CODE_POINT;
          end else if (pt == 3'd2) begin
            c[1] = c[1] | CODE_POINT;
          end else if (pt == 3'd1) begin
            c[0] = c[0] | CODE_POINT;
          end
        end
      end
    endcase

    for (int j = 0; j < CODE_N; j++) begin
      fmt_c[j] = c[j];
    end
    // Trailing fraction zeros: shift right, pad with blanks
    if ((c[0] & CODE_POINT) != CODE_ZERO) begin
      if (c[1] == CODE_ZERO && c[2] == CODE_ZERO && c[3] == CODE_ZERO) begin
        fmt_c[0] = CODE_BLANK; fmt_c[1] = CODE_BLANK; fmt_c[2] = CODE_BLANK;
        fmt_c[3] = c[0] & CODE_DIGIT;
      end else if (c[2] == CODE_ZERO && c[3] == CODE_ZERO) begin
        fmt_c[0] = CODE_BLANK; fmt_c[1] = CODE_BLANK; fmt_c[2] = c[0]; fmt_c[3] = c[1];
      end else if (c[3] == CODE_ZERO) begin
        fmt_c[0] = CODE_BLANK; fmt_c[1] = c[0]; fmt_c[2] = c[1]; fmt_c[3] = c[2];
      end
    end else if ((c[1] & CODE_POINT) != CODE_ZERO) begin
      if (c[2] == CODE_ZERO && c[3] == CODE_ZERO) begin
        fmt_c[0] = CODE_BLANK; fmt_c[1] = CODE_BLANK; fmt_c[2] = c[0];
        fmt_c[3] = c[1] & CODE_DIGIT;
      end else if (c[3] == CODE_ZERO) begin
        fmt_c[0] = CODE_BLANK; fmt_c[1] = c[0]; fmt_c[2] = c[1]; fmt_c[3] = c[2];
      end
    end else if ((c[2] & CODE_POINT) != CODE_ZERO) begin
      if (c[3] == CODE_ZERO) begin
        fmt_c[0] = CODE_BLANK; fmt_c[1] = c[0]; fmt_c[2] = c[1];
        fmt_c[3] = c[2] & CODE_DIGIT;
      end
    end
  end

  // Sequencer, display state and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
      last_r      <= LAST_RESET;
      for (int j = 0; j < CODE_N; j++) begin
        codes_r[j] <= CODE_ZERO;
      end
    end else begin
      // Output handshake: load from the result stage, else drain
      if ((state_r == ST_DONE) && (!out_valid_r || out_ch.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_ch.kind == KIND_DIGIT) begin
              if (pos_ok) begin
                codes_r[pos_idx] <= in_ch.digit_code;
              end
              state_r <= ST_DONE;
            end else if (!repeat_hit) begin
              first_r <= 1'b0;
              last_r  <= in_ch.value_milli;
              cls_r   <= cls_in;
              neg_r   <= in_ch.value_milli[VAL_W-1];
              state_r <= ST_CONV;
            end
          end
        end
        ST_CONV: begin
          if (bcd_done) begin
            for (int j = 0; j < CODE_N; j++) begin
              codes_r[j] <= fmt_c[j];
            end
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            for (int j = 0; j < CODE_N; j++) begin
              out_code_r[j] <= codes_r[j];
            end
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.code_first  = out_code_r[0];
  assign out_ch.code_second = out_code_r[1];
  assign out_ch.code_third  = out_code_r[2];
  assign out_ch.code_fourth = out_code_r[3];

  // Converter finishes only while a number is being converted
  `FDND_ASSERT_NEVER(a_done_outside_conv, clk, rst_n, bcd_done && (state_r != ST_CONV))
  // A digit word always heads for the output stage
  `FDND_ASSERT(a_digit_to_done, clk, rst_n, (in_fire && (in_ch.kind == KIND_DIGIT)) |=> (state_r == ST_DONE))
  // Output register is loaded only from the result stage
  `FDND_ASSERT(a_load_from_done, clk, rst_n, $rose(out_valid_r) |-> $past(state_r == ST_DONE))

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import fdnd_pkg::*;

  localparam int MILLI        = 1000;
  localparam int N_DIRECTED   = 25;
  localparam int N_RANDOM     = 1150;
  localparam int PAUSE_AT     = 600;
  localparam int HOLD_AT      = 60;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 64;
  localparam int CYCLE_LIMIT  = 400000;

  // Four display codes, index 0 is the leftmost digit
  typedef logic [0:3][7:0] disp_word_t;

  typedef struct packed {
    logic       kind;
    logic [24:0] value;
    logic [2:0] pos;
    code_t      code;
    logic       typed;        // expected codes are typed in below
    logic       typed_gives;
    disp_word_t typed_codes;
  } stim_row_t;

  // Directed words: extremes, both kinds, repeat suppression, bad positions
  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{KIND_DIGIT,  25'd0,            3'd1, 8'h05, 1'b1, 1'b1, 32'h05000000},
    '{KIND_NUMBER, 25'd0,            3'd0, 8'h00, 1'b1, 1'b1, 32'h40404000},
    '{KIND_NUMBER, 25'd0,            3'd0, 8'h00, 1'b1, 1'b0, 32'h00000000},
    '{KIND_NUMBER, 25'sd9999000,     3'd0, 8'h00, 1'b1, 1'b1, 32'h09090909},
    '{KIND_NUMBER, 25'sd10000000,    3'd0, 8'h00, 1'b1, 1'b1, 32'h09090909},
    '{KIND_NUMBER, 25'sd10000000,    3'd0, 8'h00, 1'b1, 1'b0, 32'h00000000},
    '{KIND_NUMBER, -25'sd999000,     3'd0, 8'h00, 1'b1, 1'b1, 32'h10090909},
    '{KIND_NUMBER, -25'sd10000000,   3'd0, 8'h00, 1'b1, 1'b1, 32'h10090909},
    '{KIND_NUMBER, 25'h1000000,      3'd0, 8'h00, 1'b1, 1'b1, 32'h10090909},
    '{KIND_NUMBER, 25'h0ffffff,      3'd0, 8'h00, 1'b1, 1'b1, 32'h09090909},
    '{KIND_NUMBER, 25'sd1,           3'd7, 8'hff, 1'b1, 1'b1, 32'h20000001},
    '{KIND_NUMBER, 25'sd1000,        3'd0, 8'h00, 1'b1, 1'b1, 32'h40404001},
    '{KIND_NUMBER, -25'sd1,          3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, 25'sd1234567,     3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, 25'sd12500,       3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, 25'sd120000,      3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, -25'sd12340,      3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, -25'sd5000,       3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_DIGIT,  25'h1ffffff,      3'd4, 8'hff, 1'b0, 1'b0, 32'h00000000},
    '{KIND_DIGIT,  25'd0,            3'd0, 8'h33, 1'b0, 1'b0, 32'h00000000},
    '{KIND_DIGIT,  25'd0,            3'd7, 8'haa, 1'b0, 1'b0, 32'h00000000},
    '{KIND_DIGIT,  25'd0,            3'd2, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, 25'sd9998999,     3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, -25'sd998999,     3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000},
    '{KIND_NUMBER, 25'd0,            3'd0, 8'h00, 1'b0, 1'b0, 32'h00000000}
  };

  logic clk;
  logic rst_n;

  fdnd_in_if  in_bus ();
  fdnd_out_if out_bus ();

  four_digit_number_display_formatter_core i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  // Predicted display state
  disp_word_t         held_codes;
  logic signed [24:0] prior_value;
  bit                 first_number;

  disp_word_t pending_displays [$];
  int         fail_count;
  bit         sender_burst;
  bit         receiver_burst;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Split a value in thousandths into four display codes
  function automatic disp_word_t format_thousandths(input int v);
    disp_word_t c;
    int n, ip, fp, k, pt;
    int d [7];
    bit neg;
    if (v >= int'(SAT_HIGH_MILLI)) begin
      c = {CODE_NINE, CODE_NINE, CODE_NINE, CODE_NINE};
    end else if (v <= int'(SAT_LOW_MILLI)) begin
      c = {CODE_MINUS, CODE_NINE, CODE_NINE, CODE_NINE};
    end else if (v == 0) begin
      c = {CODE_BLANK, CODE_BLANK, CODE_BLANK, CODE_ZERO};
    end else begin
      neg = v < 0;
      n = neg ? -v : v;
      ip = n / MILLI;
      fp = n % MILLI;
      d[0] = ip / 1000 % 10;
      d[1] = ip / 100 % 10;
      d[2] = ip / 10 % 10;
      d[3] = ip % 10;
      d[4] = fp / 100;
      d[5] = fp / 10 % 10;
      d[6] = fp % 10;
      // first nonzero integer digit, or the units zero for pure fractions
      if (ip >= 1) begin
        k = 0;
        while (k < 3 && d[k] == 0) k++;
        pt = 4 - k;
      end else begin
        k = 3;
        pt = 1;
      end
      if (neg) begin
        c = {CODE_MINUS, code_t'(d[k]), code_t'(d[k+1]), code_t'(d[k+2])};
        if (pt == 2) c[2] |= CODE_POINT;
        else if (pt == 1) c[1] |= CODE_POINT;
      end else begin
        c = {code_t'(d[k]), code_t'(d[k+1]), code_t'(d[k+2]), code_t'(d[k+3])};
        if (pt == 3) c[2] |= CODE_POINT;
        else if (pt == 2) c[1] |= CODE_POINT;
        else if (pt == 1) c[0] |= CODE_POINT;
      end
    end

    // drop trailing fraction zeros, shifting right and padding with blanks
    if ((c[0] & CODE_POINT) != 8'h00) begin
      if (c[1] == CODE_ZERO && c[2] == CODE_ZERO && c[3] == CODE_ZERO) begin
        c = {CODE_BLANK, CODE_BLANK, CODE_BLANK, c[0] & CODE_DIGIT};
      end else if (c[2] == CODE_ZERO && c[3] == CODE_ZERO) begin
        c = {CODE_BLANK, CODE_BLANK, c[0], c[1]};
      end else if (c[3] == CODE_ZERO) begin
        c = {CODE_BLANK, c[0], c[1], c[2]};
      end
    end else if ((c[1] & CODE_POINT) != 8'h00) begin
      if (c[2] == CODE_ZERO && c[3] == CODE_ZERO) begin
        c = {CODE_BLANK, CODE_BLANK, c[0], c[1] & CODE_DIGIT};
      end else if (c[3] == CODE_ZERO) begin
        c = {CODE_BLANK, c[0], c[1], c[2]};
      end
    end else if ((c[2] & CODE_POINT) != 8'h00) begin
      if (c[3] == CODE_ZERO) begin
        c = {CODE_BLANK, c[0], c[1], c[2] & CODE_DIGIT};
      end
    end
    return c;
  endfunction

  // Advance the display state by one word; returns 1 when a result follows
  function automatic bit predict_display(input logic kind, input logic [24:0] raw_value,
                                         input logic [2:0] pos, input code_t code,
                                         output disp_word_t shown);
    logic signed [24:0] v;
    v = $signed(raw_value);
    shown = held_codes;
    if (kind == KIND_NUMBER) begin
      if (!first_number && v == prior_value) return 1'b0;
      first_number = 1'b0;
      prior_value = v;
      held_codes = format_thousandths(int'(v));
    end else if (pos >= 3'd1 && pos <= 3'd4) begin
      held_codes[pos - 3'd1] = code;
    end
    shown = held_codes;
    return 1'b1;
  endfunction

  function automatic logic [24:0] pick_value(input logic [24:0] prev);
    int mag;
    bit neg;
    neg = ($urandom_range(0, 1) == 1);
    case ($urandom_range(0, 9))
      0: mag = int'($urandom_range(0, 999));
      1: mag = int'($urandom_range(1, 9999)) * MILLI;
      2: mag = int'($urandom_range(1, 99999)) * 100;
      3: mag = int'($urandom_range(1, 999999)) * 10;
      4: mag = int'($urandom_range(0, 10000000));
      5: begin
        mag = 9999000 + int'($urandom_range(0, 6)) - 3;
        neg = 1'b0;
      end
      6: begin
        mag = 999000 + int'($urandom_range(0, 6)) - 3;
        neg = 1'b1;
      end
      7: return 25'($urandom);
      8: return prev;
      default: mag = int'($urandom_range(1, 9999));
    endcase
    return 25'(neg ? -mag : mag);
  endfunction

  // Offer one word; starts and ends on a falling edge
  task automatic offer_word(input logic kind, input logic [24:0] value, input logic [2:0] pos,
                            input code_t code, input bit typed, input bit typed_gives,
                            input disp_word_t typed_codes);
    int gap;
    bit gives;
    disp_word_t shown;
    gap = sender_burst ? 0 : int'($urandom_range(0, 16));
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_bus.valid          <= 1'b1;
    in_bus.kind           <= kind;
    in_bus.value_milli    <= value;
    in_bus.digit_position <= pos;
    in_bus.digit_code     <= code;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    gives = predict_display(kind, value, pos, code, shown);
    if (typed) begin
      gives = typed_gives;
      shown = typed_codes;
    end
    if (gives) pending_displays.push_back(shown);
    @(negedge clk);
  endtask

  task automatic check_field(input string name, input code_t want, input code_t got);
    if (want !== got) begin
      $error("%s: expected 0x%02h, actual 0x%02h", name, want, got);
      fail_count++;
    end
  endtask

  // Stimulus and verdict
  initial begin
    logic       kind_r;
    logic [24:0] value_r;
    logic [24:0] prev_number;
    logic [2:0] pos_r;
    code_t      code_r;

    rst_n                 = 1'b0;
    in_bus.valid          = 1'b0;
    in_bus.kind           = KIND_NUMBER;
    in_bus.value_milli    = '0;
    in_bus.digit_position = '0;
    in_bus.digit_code     = '0;
    held_codes            = '0;
    prior_value           = LAST_RESET;
    first_number          = 1'b1;
    fail_count            = 0;
    sender_burst          = 1'b0;
    prev_number           = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      offer_word(DIRECTED_ROWS[i].kind, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].pos,
                 DIRECTED_ROWS[i].code, DIRECTED_ROWS[i].typed,
                 DIRECTED_ROWS[i].typed_gives, DIRECTED_ROWS[i].typed_codes);
      if (DIRECTED_ROWS[i].kind == KIND_NUMBER) prev_number = DIRECTED_ROWS[i].value;
    end

    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 64 == 0) sender_burst = ($urandom_range(0, 3) == 0);
      // let the block drain completely once
      if (i == PAUSE_AT) begin
        in_bus.valid <= 1'b0;
        @(negedge clk);
        while (pending_displays.size() != 0) @(negedge clk);
      end
      kind_r  = ($urandom_range(0, 4) == 0) ? KIND_DIGIT : KIND_NUMBER;
      value_r = pick_value(prev_number);
      pos_r   = 3'($urandom_range(0, 7));
      code_r  = 8'($urandom);
      if (kind_r == KIND_NUMBER) prev_number = value_r;
      offer_word(kind_r, value_r, pos_r, code_r, 1'b0, 1'b0, '0);
    end
    in_bus.valid <= 1'b0;

    while (pending_displays.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  // Result side: random back-pressure, one long hold-off
  initial begin
    int gap;
    int words_seen;
    disp_word_t want;

    out_bus.ready  = 1'b0;
    receiver_burst = 1'b0;
    words_seen     = 0;
    @(negedge clk);
    while (!rst_n) @(negedge clk);
    forever begin
      if (words_seen % 64 == 0) receiver_burst = ($urandom_range(0, 3) == 0);
      if (words_seen == HOLD_AT) gap = HOLD_CYCLES;
      else gap = receiver_burst ? 0 : int'($urandom_range(0, 16));
      if (gap > 0) begin
        out_bus.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_bus.ready <= 1'b1;
      @(posedge clk);
      while (!out_bus.valid) @(posedge clk);
      if (pending_displays.size() == 0) begin
        $error("display word with nothing expected: %02h %02h %02h %02h",
               out_bus.code_first, out_bus.code_second, out_bus.code_third,
               out_bus.code_fourth);
        fail_count++;
      end else begin
        want = pending_displays.pop_front();
        check_field("code_first", want[0], out_bus.code_first);
        check_field("code_second", want[1], out_bus.code_second);
        check_field("code_third", want[2], out_bus.code_third);
        check_field("code_fourth", want[3], out_bus.code_fourth);
      end
      words_seen++;
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("tb_top NOT OK");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/fdnd_pkg.sv
rtl/core/fdnd_if.sv
rtl/core/fdnd_bcd.sv
rtl/core/four_digit_number_display_formatter_core.sv
tb/sv/tb_top.sv
